FILE: rtl/core/wbps_pkg.sv
// ----------------------------------------------------------------------------
// wbps_pkg: shared types and constants for the wildcard byte pattern scan
// Pattern sizing, configuration register codes and the structs that carry
// configuration and step control from the top level into the window cells.
// ----------------------------------------------------------------------------
package wbps_pkg;

  // Fixed pattern storage: two 64-bit registers hold sixteen bytes
  localparam int unsigned PAT_BYTES  = 16;
  localparam int unsigned PAT_IDX_W  = 4;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned LEN_W      = 5;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned ADDR_W     = 64;
  // Compare width for lengths against cell positions (positions up to 127)
  localparam int unsigned CMP_W      = 7;

  // Defaults for the top-level parameters
  localparam int unsigned DEF_MAX_PATTERN_LENGTH = 16;
  localparam int unsigned DEF_OFFSET_BITS        = 32;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_LOW  = 3'd0,
    REG_PATTERN_HIGH = 3'd1,
    REG_WILDCARD     = 3'd2,
    REG_LENGTH       = 3'd3,
    REG_REGION_BASE  = 3'd4
  } cfg_reg_e;

  typedef logic [PAT_BYTES-1:0][BYTE_W-1:0] pat_t;

  // Pattern setup seen by every cell
  typedef struct packed {
    pat_t                 pattern;
    logic [PAT_BYTES-1:0] wild;
    logic [LEN_W-1:0]     len;
  } cell_cfg_t;

  // Per-word control of the window chain
  typedef struct packed {
    logic shift;
    logic clear;
  } step_t;

endpackage

FILE: rtl/core/wbps_cell.sv
// ----------------------------------------------------------------------------
// wbps_cell: one window position of the pattern scan
// Holds one byte of the window, passes it to the next cell on every accepted
// word, and checks the byte it is about to take against its pattern byte.
// ----------------------------------------------------------------------------
module wbps_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  wbps_pkg::step_t            step_i,
  input  wbps_pkg::cell_cfg_t        cfg_i,
  input  logic [wbps_pkg::BYTE_W-1:0] byte_i,
  output logic [wbps_pkg::BYTE_W-1:0] byte_o,
  output logic                       hit_o
);
  import wbps_pkg::*;

  localparam logic [CMP_W-1:0] POS = CMP_W'(IDX);

  logic [CMP_W-1:0]     len_ext;
  logic [CMP_W-1:0]     sel_full;
  logic [PAT_IDX_W-1:0] sel;
  logic                 active;
  logic [BYTE_W-1:0]    byte_d, byte_q;

  // Newest byte sits in cell 0, so this cell faces pattern byte len-1-IDX
  assign len_ext  = CMP_W'(cfg_i.len);
  assign active   = len_ext > POS;
  assign sel_full = len_ext - POS - CMP_W'(1);
  assign sel      = sel_full[PAT_IDX_W-1:0];

  // Cells outside the pattern never veto a match
  assign hit_o = !active || cfg_i.wild[sel] || (byte_i == cfg_i.pattern[sel]);

  // Window byte: shift on each word, clear at region end
  always_comb begin
    byte_d = byte_q;
    if (step_i.clear) begin
      byte_d = '0;
    end else if (step_i.shift) begin
      byte_d = byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= '0;
    end else begin
      byte_q <= byte_d;
    end
  end

  assign byte_o = byte_q;

endmodule

FILE: rtl/core/wildcard_byte_pattern_scan.sv
// A result word appears in the output register in the cycle after the
// input word that causes it is accepted. Throughput: one byte per cycle
// unless stalled; all window cells compare in the same cycle.
// Input stalls only while a result waits and the output side stalls.
// Reset clears the window, byte count, match flag, config and output valid.
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_scan: first-match byte pattern search with wildcards
// A chain of window cells shifts in one byte per word; a match or a not-found
// at region end yields one result word holding found and the match address.
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_scan #(
  parameter int unsigned MAX_PATTERN_LENGTH = wbps_pkg::DEF_MAX_PATTERN_LENGTH,
  parameter int unsigned OFFSET_BITS        = wbps_pkg::DEF_OFFSET_BITS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write port
  input  logic                            cfg_we_i,
  input  logic [wbps_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [wbps_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // input channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [wbps_pkg::BYTE_W-1:0]     data_byte_i,
  input  logic                            last_byte_i,
  // output channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            found_o,
  output logic [wbps_pkg::ADDR_W-1:0]     match_address_o
);
  import wbps_pkg::*;

  // Configuration registers
  logic [CFG_DATA_W-1:0] pat_lo_q, pat_hi_q, base_q;
  logic [PAT_BYTES-1:0]  wild_q;
  logic [LEN_W-1:0]      len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_lo_q <= '0;
      pat_hi_q <= '0;
      base_q   <= '0;
      wild_q   <= '0;
      len_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_PATTERN_LOW:  pat_lo_q <= cfg_data_i;
        REG_PATTERN_HIGH: pat_hi_q <= cfg_data_i;
        REG_WILDCARD:     wild_q   <= cfg_data_i[PAT_BYTES-1:0];
        REG_LENGTH:       len_q    <= cfg_data_i[LEN_W-1:0];
        REG_REGION_BASE:  base_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  cell_cfg_t cell_cfg;
  assign cell_cfg.pattern = {pat_hi_q, pat_lo_q};
  assign cell_cfg.wild    = wild_q;
  assign cell_cfg.len     = len_q;

  // Handshake
  logic accept;
  logic out_valid_q;
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  step_t step;
  assign step.shift = accept;
  assign step.clear = accept && last_byte_i;

  // Window chain
  logic [MAX_PATTERN_LENGTH-1:0][BYTE_W-1:0] win;
  logic [MAX_PATTERN_LENGTH-1:0]             hits;

  for (genvar j = 0; j < MAX_PATTERN_LENGTH; j++) begin : g_cell
    logic [BYTE_W-1:0] feed;
    if (j == 0) begin : g_head
      assign feed = data_byte_i;
    end else begin : g_link
      assign feed = win[j-1];
    end
    wbps_cell #(.IDX(j)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .step_i (step),
      .cfg_i  (cell_cfg),
      .byte_i (feed),
      .byte_o (win[j]),
      .hit_o  (hits[j])
    );
  end

  // Byte count and match flag
  logic [OFFSET_BITS-1:0] count_d, count_q, count_next, offset;
  logic                   reported_d, reported_q;
  logic                   counted, len_ok, enough, match, result;
  logic [ADDR_W-1:0]      addr;

  assign counted    = ~&count_q;
  assign count_next = count_q + OFFSET_BITS'(1);
  assign len_ok     = (len_q != '0) && (CMP_W'(len_q) <= CMP_W'(PAT_BYTES)) &&
                      (CMP_W'(len_q) <= CMP_W'(MAX_PATTERN_LENGTH));
  assign enough     = count_next >= OFFSET_BITS'(len_q);
  assign match      = !reported_q && counted && len_ok && enough && (&hits);
  assign result     = match || (last_byte_i && !reported_q);
  assign offset     = count_next - OFFSET_BITS'(len_q);
  assign addr       = base_q + ADDR_W'(offset);

  always_comb begin
    count_d    = count_q;
    reported_d = reported_q;
    if (accept) begin
      if (last_byte_i) begin
        count_d    = '0;
        reported_d = 1'b0;
      end else begin
        if (counted) begin
          count_d = count_next;
        end
        reported_d = reported_q || match;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      reported_q <= 1'b0;
    end else begin
      count_q    <= count_d;
      reported_q <= reported_d;
    end
  end

  // Output register
  logic              found_q;
  logic [ADDR_W-1:0] addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept && result) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && result) begin
      found_q <= match;
      addr_q  <= match ? addr : '0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign found_o         = found_q;
  assign match_address_o = addr_q;

  // Assertions
  a_result_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && result |=> out_valid_o)
    else $error("result word not registered");

  a_notfound_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> match_address_o == '0)
    else $error("not-found word carries an address");

  a_region_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && last_byte_i |=> count_q == '0 && !reported_q)
    else $error("scan state not cleared at region end");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output register");

  a_single_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    reported_q |-> !match)
    else $error("second match in one region");

endmodule
